>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the line editor RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

>>> hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Types, codes and echo tables for the canonical line editor
// ----------------------------------------------------------------------------
package cle_pkg;

  typedef logic [7:0] byte_t;

  // operation codes
  localparam logic [1:0] OP_KEY     = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CONSUME = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  // raise signal codes
  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_STOP = 2'd2;

  // key codes and echo bytes
  localparam byte_t KEY_CTRL_C    = 8'h03;
  localparam byte_t KEY_CTRL_D    = 8'h04;
  localparam byte_t KEY_BACKSPACE = 8'h08;
  localparam byte_t KEY_ENTER     = 8'h0A;
  localparam byte_t KEY_CTRL_Z    = 8'h1A;
  localparam byte_t CHAR_SPACE    = 8'h20;
  localparam byte_t CHAR_CARET    = 8'h5E;
  localparam byte_t CHAR_UPPER_C  = 8'h43;
  localparam byte_t CHAR_UPPER_Z  = 8'h5A;

  // echo sequence kinds
  localparam logic [2:0] SEQ_NONE  = 3'd0;  // one word, no echo
  localparam logic [2:0] SEQ_ONE   = 3'd1;  // one word echoing ch
  localparam logic [2:0] SEQ_INTR  = 3'd2;  // ^C newline
  localparam logic [2:0] SEQ_STOP  = 3'd3;  // ^Z newline
  localparam logic [2:0] SEQ_ERASE = 3'd4;  // backspace space backspace

  // one decoded item handed from the edit control to the echo sequencer
  typedef struct packed {
    logic [2:0] kind;
    byte_t      ch;
    logic [1:0] sig;
    logic       line_evt;
    logic       ready;
    logic       eof;
    byte_t      length;
    logic       hit;
  } item_t;

  // index of the final word of a sequence
  function automatic logic [1:0] seq_last_beat(input logic [2:0] kind);
    logic [1:0] res;
    case (kind)
      SEQ_INTR, SEQ_STOP, SEQ_ERASE: res = 2'd2;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  // echo byte for a given word of a sequence
  function automatic byte_t seq_echo_char(input logic [2:0] kind,
                                          input logic [1:0] beat,
                                          input byte_t ch);
    byte_t res;
    res = 8'h00;
    case (kind)
      SEQ_ONE: res = ch;
      SEQ_INTR: begin
        case (beat)
          2'd0: res = CHAR_CARET;
          2'd1: res = CHAR_UPPER_C;
          default: res = KEY_ENTER;
        endcase
      end
      SEQ_STOP: begin
        case (beat)
          2'd0: res = CHAR_CARET;
          2'd1: res = CHAR_UPPER_Z;
          default: res = KEY_ENTER;
        endcase
      end
      SEQ_ERASE: begin
        case (beat)
          2'd1: res = CHAR_SPACE;
          default: res = KEY_BACKSPACE;
        endcase
      end
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/cle_line_mem.sv
// ----------------------------------------------------------------------------
// cle_line_mem
// Line byte store: one write port, one registered read port
// ----------------------------------------------------------------------------
module cle_line_mem
  import cle_pkg::*;
#(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  byte_t             wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output byte_t             rdata
);

  byte_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cle_edit_ctrl.sv
// ----------------------------------------------------------------------------
// cle_edit_ctrl
// Decodes input words, updates length and flags, issues store accesses
// and holds one decoded item for the echo sequencer
// ----------------------------------------------------------------------------
module cle_edit_ctrl
  import cle_pkg::*;
#(
  parameter int LINE_SIZE = 256,
  parameter int ADDR_W    = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic              is_press,
  input  byte_t             key_code,
  input  byte_t             read_index,
  input  logic              b_take,
  output logic              b_valid,
  output item_t             b_item,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output byte_t             mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr
);

  localparam int LEN_W = ADDR_W;
  localparam int CMP_W = (ADDR_W > 8) ? ADDR_W : 8;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_SIZE - 1);

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic             ready;
  logic             ready_next;
  logic             eof;
  logic             eof_next;
  logic             accept;
  logic             wr_req;
  logic             rd_hit;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_next_ext;
  item_t            item_new;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = b_valid & ~b_take;

  assign idx_ext      = CMP_W'(read_index);
  assign len_ext      = CMP_W'(len);
  assign len_next_ext = CMP_W'(len_next);
  assign rd_hit       = (idx_ext < len_ext);

  // decode of one word against current length and flags
  always_comb begin
    len_next   = len;
    ready_next = ready;
    eof_next   = eof;
    wr_req     = 1'b0;
    item_new   = '0;
    item_new.kind = SEQ_NONE;
    item_new.sig  = SIG_NONE;
    case (op)
      OP_READ: begin
        item_new.hit = rd_hit;
      end
      OP_CONSUME: begin
        ready_next = 1'b0;
        eof_next   = 1'b0;
      end
      OP_RESET: begin
        len_next   = '0;
        ready_next = 1'b0;
        eof_next   = 1'b0;
      end
      OP_KEY: begin
        if (is_press) begin
          if (key_code == KEY_CTRL_C) begin
            len_next      = '0;
            item_new.kind = SEQ_INTR;
            item_new.sig  = SIG_INTR;
          end else if (key_code == KEY_CTRL_Z) begin
            item_new.kind = SEQ_STOP;
            item_new.sig  = SIG_STOP;
          end else if (key_code == KEY_CTRL_D) begin
            if (len == '0) begin
              eof_next          = 1'b1;
              item_new.line_evt = 1'b1;
            end
          end else if (key_code == KEY_ENTER) begin
            ready_next        = 1'b1;
            item_new.kind     = SEQ_ONE;
            item_new.ch       = KEY_ENTER;
            item_new.line_evt = 1'b1;
          end else if (key_code == KEY_BACKSPACE) begin
            if (len != '0) begin
              len_next      = len - LEN_W'(1);
              item_new.kind = SEQ_ERASE;
            end
          end else if (key_code >= CHAR_SPACE) begin
            if (len < LEN_MAX) begin
              wr_req        = 1'b1;
              len_next      = len + LEN_W'(1);
              item_new.kind = SEQ_ONE;
              item_new.ch   = key_code;
            end
          end
        end
      end
      default: begin
        len_next = len;
      end
    endcase
    item_new.ready  = ready_next;
    item_new.eof    = eof_next;
    item_new.length = len_next_ext[7:0];
  end

  // store accesses, taken only with an accepted word
  assign mem_we    = accept & wr_req;
  assign mem_waddr = len;
  assign mem_wdata = key_code;
  assign mem_re    = accept & (op == OP_READ) & rd_hit;
  assign mem_raddr = idx_ext[ADDR_W-1:0];

  // line length and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      len   <= '0;
      ready <= 1'b0;
      eof   <= 1'b0;
    end else if (accept) begin
      len   <= len_next;
      ready <= ready_next;
      eof   <= eof_next;
    end
  end

  // decoded item stage, lines up with the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item <= item_new;
    end
  end

endmodule

>>> hdl/cle_echo_seq.sv
// ----------------------------------------------------------------------------
// cle_echo_seq
// Output register that plays out one to three result words per item
// ----------------------------------------------------------------------------
module cle_echo_seq
  import cle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       b_valid,
  input  item_t      b_item,
  input  byte_t      mem_rdata,
  output logic       b_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       echo_valid,
  output byte_t      echo_char,
  output logic [1:0] raise_signal,
  output logic       line_event,
  output logic       ready_flag,
  output logic       eof_flag,
  output byte_t      length_now,
  output byte_t      read_byte,
  output logic       last
);

  item_t      cur;
  byte_t      rbyte;
  logic [1:0] beat;
  logic       word_done;

  assign last      = (beat == seq_last_beat(cur.kind));
  assign word_done = out_valid & ~out_stall;
  assign b_take    = b_valid & (~out_valid | (word_done & last));

  // output valid and word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= 2'd0;
    end else if (b_take) begin
      out_valid <= 1'b1;
      beat      <= 2'd0;
    end else if (word_done) begin
      if (last) begin
        out_valid <= 1'b0;
        beat      <= 2'd0;
      end else begin
        beat <= beat + 2'd1;
      end
    end
  end

  // item payload with its store read data
  always_ff @(posedge clk) begin
    if (b_take) begin
      cur   <= b_item;
      rbyte <= mem_rdata;
    end
  end

  // result fields
  assign echo_valid   = (cur.kind != SEQ_NONE);
  assign echo_char    = seq_echo_char(cur.kind, beat, cur.ch);
  assign raise_signal = last ? cur.sig : SIG_NONE;
  assign line_event   = last & cur.line_evt;
  assign ready_flag   = cur.ready;
  assign eof_flag     = cur.eof;
  assign length_now   = cur.length;
  assign read_byte    = cur.hit ? rbyte : 8'h00;

endmodule

>>> hdl/canonical_line_editor.sv
// ----------------------------------------------------------------------------
// canonical_line_editor
// Canonical-mode line editor: edits one line of key bytes in a byte store,
// echoes edits, flags line completion, end of file and signal requests
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  op, is_press, key_code, read_index
//  output   out_valid / out_stall echo_valid, echo_char, raise_signal,
//                                line_event, ready_flag, eof_flag,
//                                length_now, read_byte, last
//
//  A word is decoded in the cycle it is accepted; length and flags update
//  at that edge and the store is written or read then. The first result
//  word passes through the item stage and the output register before it
//  is presented. Items with one result go at one per cycle while out_stall
//  is low; Ctrl+C, Ctrl+Z and backspace on a non-empty line have three
//  echo words, played out in turn by the output sequencer.
//  Reset clears length and flags; the store needs no clearing pass.
//  A stalled output backs up through the item stage into in_stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module canonical_line_editor
  import cle_pkg::*;
#(
  parameter int LINE_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op,
  input  logic       is_press,
  input  byte_t      key_code,
  input  byte_t      read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       echo_valid,
  output byte_t      echo_char,
  output logic [1:0] raise_signal,
  output logic       line_event,
  output logic       ready_flag,
  output logic       eof_flag,
  output byte_t      length_now,
  output byte_t      read_byte,
  output logic       last
);

  localparam int ADDR_W = (LINE_SIZE > 2) ? $clog2(LINE_SIZE) : 1;

  logic              b_valid;
  logic              b_take;
  item_t             b_item;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  byte_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  byte_t             mem_rdata;

  // decode, length and flags
  cle_edit_ctrl #(
    .LINE_SIZE (LINE_SIZE),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .is_press   (is_press),
    .key_code   (key_code),
    .read_index (read_index),
    .b_take     (b_take),
    .b_valid    (b_valid),
    .b_item     (b_item),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr)
  );

  // line byte store
  cle_line_mem #(
    .DEPTH  (LINE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result word sequencer
  cle_echo_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .b_valid      (b_valid),
    .b_item       (b_item),
    .mem_rdata    (mem_rdata),
    .b_take       (b_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_valid   (echo_valid),
    .echo_char    (echo_char),
    .raise_signal (raise_signal),
    .line_event   (line_event),
    .ready_flag   (ready_flag),
    .eof_flag     (eof_flag),
    .length_now   (length_now),
    .read_byte    (read_byte),
    .last         (last)
  );

  // checks
  `ASSERT_NEVER(a_no_rw_same_cycle, clk, rst, mem_we && mem_re)
  `ASSERT_HOLDS(a_write_in_range, clk, rst, mem_we |-> (int'(mem_waddr) < LINE_SIZE - 1))
  `ASSERT_HOLDS(a_seq_continues, clk, rst, (out_valid && !out_stall && !last) |=> out_valid)
  `ASSERT_HOLDS(a_stall_needs_output, clk, rst, in_stall |-> (out_valid && b_valid))

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the canonical line editor. Key events, reads,
// consumes and editor resets go in through the input channel; every result
// word is checked field by field against a line-editing predictor kept in
// step with the words accepted. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import cle_pkg::*;
();

  localparam int LINE_SIZE  = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam byte_t KEY_RETURN = 8'h0D;
  localparam byte_t KEY_NUL    = 8'h00;
  localparam byte_t KEY_US     = 8'h1F;

  // one expected result word
  typedef struct {
    logic       echo_valid;
    byte_t      echo_char;
    logic [1:0] raise_signal;
    logic       line_event;
    logic       ready_flag;
    logic       eof_flag;
    byte_t      length_now;
    byte_t      read_byte;
    logic       last;
  } echo_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_KEY;
  logic       is_press = 1'b0;
  byte_t      key_code = 8'h00;
  byte_t      read_index = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       echo_valid;
  byte_t      echo_char;
  logic [1:0] raise_signal;
  logic       line_event;
  logic       ready_flag;
  logic       eof_flag;
  byte_t      length_now;
  byte_t      read_byte;
  logic       last;

  // predictor state: line bytes, length and flags
  byte_t      line_copy [LINE_SIZE];
  int         copy_len = 0;
  logic       ready_copy = 1'b0;
  logic       eof_copy = 1'b0;

  echo_word_t pending_echo [$];
  int         fail_count = 0;
  int         words_sent = 0;
  int         results_seen = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  logic       no_gaps = 1'b0;

  canonical_line_editor #(.LINE_SIZE(LINE_SIZE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .is_press(is_press), .key_code(key_code), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .echo_valid(echo_valid), .echo_char(echo_char), .raise_signal(raise_signal),
    .line_event(line_event), .ready_flag(ready_flag), .eof_flag(eof_flag),
    .length_now(length_now), .read_byte(read_byte), .last(last)
  );

  always #5 clk = ~clk;

  // queue one expected word, flags and length as they stand now
  function automatic void push_echo(logic v, byte_t ch, logic [1:0] sig, logic ev,
                                    byte_t rb, logic is_last);
    echo_word_t w;
    w.echo_valid   = v;
    w.echo_char    = v ? ch : 8'h00;
    w.raise_signal = is_last ? sig : SIG_NONE;
    w.line_event   = is_last ? ev : 1'b0;
    w.ready_flag   = ready_copy;
    w.eof_flag     = eof_copy;
    w.length_now   = copy_len[7:0];
    w.read_byte    = rb;
    w.last         = is_last;
    pending_echo.push_back(w);
  endfunction

  // three echo words, signal on the last
  function automatic void push_triple(byte_t a, byte_t b, byte_t c, logic [1:0] sig);
    push_echo(1'b1, a, SIG_NONE, 1'b0, 8'h00, 1'b0);
    push_echo(1'b1, b, SIG_NONE, 1'b0, 8'h00, 1'b0);
    push_echo(1'b1, c, sig, 1'b0, 8'h00, 1'b1);
  endfunction

  // line editing predictor for one accepted word
  function automatic void predict_edit(logic [1:0] o, logic p, byte_t k, byte_t ix);
    byte_t rb;
    rb = 8'h00;
    case (o)
      OP_READ: begin
        if (int'(ix) < copy_len) rb = line_copy[ix];
        push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, rb, 1'b1);
      end
      OP_CONSUME: begin
        ready_copy = 1'b0;
        eof_copy = 1'b0;
        push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
      end
      OP_RESET: begin
        copy_len = 0;
        ready_copy = 1'b0;
        eof_copy = 1'b0;
        push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
      end
      default: begin
        if (!p) begin
          push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
        end else if (k == KEY_CTRL_C) begin
          copy_len = 0;
          push_triple(CHAR_CARET, CHAR_UPPER_C, KEY_ENTER, SIG_INTR);
        end else if (k == KEY_CTRL_Z) begin
          push_triple(CHAR_CARET, CHAR_UPPER_Z, KEY_ENTER, SIG_STOP);
        end else if (k == KEY_CTRL_D) begin
          if (copy_len == 0) begin
            eof_copy = 1'b1;
            push_echo(1'b0, 8'h00, SIG_NONE, 1'b1, 8'h00, 1'b1);
          end else begin
            push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
          end
        end else if (k == KEY_ENTER) begin
          if (copy_len >= LINE_SIZE) copy_len = LINE_SIZE - 1;
          ready_copy = 1'b1;
          push_echo(1'b1, KEY_ENTER, SIG_NONE, 1'b1, 8'h00, 1'b1);
        end else if (k == KEY_BACKSPACE) begin
          if (copy_len > 0) begin
            copy_len--;
            push_triple(KEY_BACKSPACE, CHAR_SPACE, KEY_BACKSPACE, SIG_NONE);
          end else begin
            push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
          end
        end else if (k < CHAR_SPACE) begin
          push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
        end else if (copy_len < LINE_SIZE - 1) begin
          line_copy[copy_len[7:0]] = k;
          copy_len++;
          push_echo(1'b1, k, SIG_NONE, 1'b0, 8'h00, 1'b1);
        end else begin
          push_echo(1'b0, 8'h00, SIG_NONE, 1'b0, 8'h00, 1'b1);
        end
      end
    endcase
  endfunction

  // send one word after a random gap, predict once accepted
  task automatic send_word(logic [1:0] o, logic p, byte_t k, byte_t ix);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    is_press   <= p;
    key_code   <= k;
    read_index <= ix;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_edit(o, p, k, ix);
    words_sent++;
  endtask

  task automatic press_key(byte_t k);
    send_word(OP_KEY, 1'b1, k, byte_t'($urandom_range(0, 255)));
  endtask

  // field compare with mismatch report
  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result monitor and output stall generator
  always @(posedge clk) begin : result_monitor
    echo_word_t w;
    int n;
    n = (stall_left > 0) ? stall_left - 1 : 0;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      results_seen++;
      if (pending_echo.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        fail_count++;
      end else begin
        w = pending_echo.pop_front();
        cmp_field("echo_valid", 8'(w.echo_valid), 8'(echo_valid));
        cmp_field("echo_char", w.echo_char, echo_char);
        cmp_field("raise_signal", 8'(w.raise_signal), 8'(raise_signal));
        cmp_field("line_event", 8'(w.line_event), 8'(line_event));
        cmp_field("ready_flag", 8'(w.ready_flag), 8'(ready_flag));
        cmp_field("eof_flag", 8'(w.eof_flag), 8'(eof_flag));
        cmp_field("length_now", w.length_now, length_now);
        cmp_field("read_byte", w.read_byte, read_byte);
        cmp_field("last", 8'(w.last), 8'(last));
      end
      n = no_gaps ? 0 : $urandom_range(0, 9);
    end
    stall_left = n;
    out_stall <= (n != 0);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // extremes of every field and each special key
  task automatic test_directed();
    send_word(OP_KEY, 1'b0, 8'h78, 8'h00);          // release ignored
    send_word(OP_READ, 1'b1, 8'h41, 8'h00);         // read on empty line
    press_key(CHAR_SPACE);
    press_key(8'h7E);
    press_key(8'h7F);
    press_key(8'hFF);
    press_key(8'h41);
    send_word(OP_READ, 1'b0, 8'h00, 8'h00);
    send_word(OP_READ, 1'b0, 8'h00, 8'h04);
    send_word(OP_READ, 1'b0, 8'h00, 8'h05);         // at length
    send_word(OP_READ, 1'b1, 8'hFF, 8'hFF);         // far past length
    press_key(KEY_RETURN);                          // carriage return dropped
    press_key(KEY_NUL);
    press_key(KEY_US);
    press_key(KEY_BACKSPACE);
    press_key(KEY_CTRL_D);                          // non-empty line
    press_key(KEY_ENTER);
    send_word(OP_CONSUME, 1'b1, 8'h00, 8'h00);
    press_key(KEY_CTRL_C);
    press_key(KEY_BACKSPACE);                       // empty line
    press_key(KEY_CTRL_D);                          // empty line sets eof
    press_key(KEY_CTRL_Z);
    send_word(OP_KEY, 1'b0, KEY_CTRL_C, 8'h00);     // control release ignored
    press_key(8'h71);
    send_word(OP_RESET, 1'b0, 8'hFF, 8'hFF);
  endtask

  // mostly typing sessions with random content, some noise
  task automatic test_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) no_gaps <= ~no_gaps;
      pick = $urandom_range(0, 99);
      if (pick < 45)
        press_key(byte_t'($urandom_range(CHAR_SPACE, 255)));
      else if (pick < 55)
        press_key(KEY_BACKSPACE);
      else if (pick < 61)
        press_key(KEY_ENTER);
      else if (pick < 67)
        send_word(OP_READ, 1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, copy_len)));
      else if (pick < 71)
        send_word(OP_READ, 1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)));
      else if (pick < 76)
        send_word(OP_CONSUME, 1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)));
      else if (pick < 79)
        press_key(KEY_CTRL_C);
      else if (pick < 82)
        press_key(KEY_CTRL_Z);
      else if (pick < 86)
        press_key(KEY_CTRL_D);
      else if (pick < 88)
        send_word(OP_RESET, 1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                  byte_t'($urandom_range(0, 255)));
      else
        send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  byte_t'($urandom_range(0, 255)), byte_t'($urandom_range(0, 255)));
    end
    no_gaps <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(125);
    in_valid <= 1'b0;
    while (pending_echo.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d words: directed edits and special keys, random sessions",
             words_sent);
    $display("checked %0d result words, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cle_pkg.sv
hdl/cle_line_mem.sv
hdl/cle_edit_ctrl.sv
hdl/cle_echo_seq.sv
hdl/canonical_line_editor.sv
tb/testbench.sv
